// File: src/fic_pkg.sv
`timescale 1ns / 1ps
package fic_pkg;
    typedef enum logic [1:0] {
        KIND_U64_TO_F64 = 2'd0,
        KIND_F64_TO_I64 = 2'd1,
        KIND_F64_TO_U64 = 2'd2,
        KIND_F64_TO_U8  = 2'd3
    } kind_t;

    localparam int FRAC_BITS = 52;
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    // stage 1 to stage 2 word
    typedef struct packed {
        logic        to_float;
        logic        err;
        logic        neg;
        logic        zero_res;
        logic        min_i64;
        logic [5:0]  shamt;
        logic        left;
        logic [63:0] val;
    } s1_t;

    // stage 2 to stage 3 word
    typedef struct packed {
        logic        to_float;
        logic        err;
        logic        neg;
        logic        zero_res;
        logic        min_i64;
        logic [5:0]  pos;
        logic [63:0] val;
    } s2_t;
endpackage

// File: src/fic_lzc.sv
`timescale 1ns / 1ps
module fic_lzc
(
    input  logic [63:0] value,
    output logic [5:0]  pos,
    output logic        nonzero
);
    logic [3:0] grp_any;
    logic [3:0] grp_pos [4];

    // 16-bit groups searched in parallel, then the top group picked
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            grp_any[g] = |value[g*16 +: 16];
            grp_pos[g] = 4'd0;
            for (int b = 0; b < 16; b++)
            begin
                if (value[g*16 + b])
                begin
                    grp_pos[g] = 4'(b);
                end
            end
        end
        nonzero = |grp_any;
        priority if (grp_any[3])
        begin
            pos = {2'd3, grp_pos[3]};
        end
        else if (grp_any[2])
        begin
            pos = {2'd2, grp_pos[2]};
        end
        else if (grp_any[1])
        begin
            pos = {2'd1, grp_pos[1]};
        end
        else
        begin
            pos = {2'd0, grp_pos[0]};
        end
    end
endmodule

// File: src/float_integer_converter.sv
`timescale 1ns / 1ps
// float_integer_converter: u64 to binary64 and binary64 to i64/u64/u8
// input channel: in_valid, in_stall, kind, operand
// output channel: out_valid, out_stall, converted, range_error
// kind 0 converts an unsigned integer to a double, round to nearest even
// kinds 1..3 truncate a double toward zero; nan, infinity and values out of
// the target range raise range_error and give a zero result
// three register stages: decode and leading-one search, shift, then
// rounding or negation into the output register
// out_valid rises once the word has passed the stage 1, stage 2 and output
// registers; one word per cycle while out_stall is low
// a stage moves forward when it is empty or the stage after it moves, so
// a stall at the output fills the pipe and then holds in_stall high
// no word is dropped or repeated under any stall pattern
// reset clears all valid bits; payload registers are not reset
module float_integer_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] converted,
    output logic        range_error
);
    logic v1_reg, v2_reg, v3_reg;
    fic_pkg::s1_t s1_reg, s1_next;
    fic_pkg::s2_t s2_reg, s2_next;
    logic [63:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic mv3, mv2, mv1;

    assign mv3 = !v3_reg || !out_stall;
    assign mv2 = !v2_reg || mv3;
    assign mv1 = !v1_reg || mv2;
    assign in_stall = !mv1;
    assign out_valid = v3_reg;
    assign converted = res_reg;
    assign range_error = err_reg;

    logic [5:0] lz_pos;
    logic       lz_nz;
    fic_lzc u_lzc (.value(operand), .pos(lz_pos), .nonzero(lz_nz));

    // stage 1: classify and work out shift
    logic        neg;
    logic [10:0] e;
    logic [51:0] frac;
    logic [11:0] ue;
    logic        below_one;
    fic_pkg::kind_t k;
    always_comb
    begin
        k = fic_pkg::kind_t'(kind);
        neg = operand[63];
        e = operand[62:52];
        frac = operand[51:0];
        ue = {1'b0, e} - {1'b0, fic_pkg::EXP_BIAS};
        below_one = e < fic_pkg::EXP_BIAS;
        s1_next = '0;
        s1_next.neg = neg;
        s1_next.val = {11'd1, frac};
        unique case (k)
            fic_pkg::KIND_U64_TO_F64:
            begin
                s1_next.to_float = 1'b1;
                s1_next.zero_res = !lz_nz;
                s1_next.shamt = lz_pos;
                s1_next.val = operand;
            end
            fic_pkg::KIND_F64_TO_I64:
            begin
                if (e == fic_pkg::EXP_MAX)
                begin
                    s1_next.err = 1'b1;
                end
                else if (!below_one && ue >= 12'd63)
                begin
                    if (neg && ue == 12'd63 && frac == '0)
                    begin
                        s1_next.min_i64 = 1'b1;
                    end
                    else
                    begin
                        s1_next.err = 1'b1;
                    end
                end
                else
                begin
                    s1_next.zero_res = below_one;
                end
            end
            default:
            begin
                if (e == fic_pkg::EXP_MAX)
                begin
                    s1_next.err = 1'b1;
                end
                else if (neg && (e != '0 || frac != '0))
                begin
                    s1_next.err = 1'b1;
                end
                else if (!below_one
                         && ue >= ((k == fic_pkg::KIND_F64_TO_U64) ? 12'd64 : 12'd8))
                begin
                    s1_next.err = 1'b1;
                end
                else
                begin
                    s1_next.zero_res = below_one;
                end
                s1_next.neg = 1'b0;
            end
        endcase
        if (!s1_next.to_float)
        begin
            if (ue[5:0] <= 6'd52)
            begin
                s1_next.left = 1'b0;
                s1_next.shamt = 6'd52 - ue[5:0];
            end
            else
            begin
                s1_next.left = 1'b1;
                s1_next.shamt = ue[5:0] - 6'd52;
            end
        end
    end

    // stage 2: alignment shift; float path moves the leading one to bit 63
    logic [6:0]  fsh;
    always_comb
    begin
        s2_next.to_float = s1_reg.to_float;
        s2_next.err = s1_reg.err;
        s2_next.neg = s1_reg.neg;
        s2_next.zero_res = s1_reg.zero_res;
        s2_next.min_i64 = s1_reg.min_i64;
        s2_next.pos = s1_reg.shamt;
        fsh = 7'd0;
        if (s1_reg.to_float)
        begin
            // place leading one at bit 63
            fsh = 7'd63 - {1'b0, s1_reg.shamt};
            s2_next.val = s1_reg.val << fsh;
        end
        else if (s1_reg.left)
        begin
            s2_next.val = s1_reg.val << s1_reg.shamt;
        end
        else
        begin
            s2_next.val = s1_reg.val >> s1_reg.shamt;
        end
    end

    // stage 3: round or negate
    logic [52:0] q;
    logic        rb, st;
    logic [53:0] qr;
    logic [10:0] ex;
    always_comb
    begin
        q = s2_reg.val[63:11];
        rb = s2_reg.val[10];
        st = |s2_reg.val[9:0];
        qr = {1'b0, q} + {53'd0, (rb && (st || q[0]))};
        ex = 11'(s2_reg.pos) + fic_pkg::EXP_BIAS;
        err_next = s2_reg.err;
        if (s2_reg.err || s2_reg.zero_res)
        begin
            res_next = '0;
        end
        else if (s2_reg.to_float)
        begin
            if (qr[53])
            begin
                res_next = {1'b0, ex + 11'd1, 52'd0};
            end
            else
            begin
                res_next = {1'b0, ex, qr[51:0]};
            end
        end
        else if (s2_reg.min_i64)
        begin
            res_next = {1'b1, 63'd0};
        end
        else if (s2_reg.neg)
        begin
            res_next = 64'd0 - s2_reg.val;
        end
        else
        begin
            res_next = s2_reg.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (mv1)
            begin
                v1_reg <= in_valid;
            end
            if (mv2)
            begin
                v2_reg <= v1_reg;
            end
            if (mv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            s1_reg <= s1_next;
        end
        if (mv2)
        begin
            s2_reg <= s2_next;
        end
        if (mv3)
        begin
            res_reg <= res_next;
            err_reg <= err_next;
        end
    end
endmodule
